// ===== rtl/glcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Graphic LCD refresh unit package
// Shared types, opcodes, result codes and LCD command constants.
// ----------------------------------------------------------------------------
package glcd_pkg;

   localparam int SCREEN_COLUMNS = 128;
   localparam int PAGE_COUNT     = 8;
   localparam int CHIP_COLUMNS   = 64;
   localparam int STORE_PAGES    = 8;
   localparam int ROW_BITS       = STORE_PAGES * 8;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_PIXEL  = 3'd1;
   localparam logic [2:0] OP_REDRAW = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_INIT   = 3'd4;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   localparam logic [1:0] CHIP_A    = 2'd0;
   localparam logic [1:0] CHIP_B    = 2'd1;
   localparam logic [1:0] CHIP_BOTH = 2'd2;

   localparam logic [7:0] PAGE_CMD_MASK = 8'hBF;
   localparam logic [7:0] PAGE_CMD_BASE = 8'hB8;
   localparam logic [7:0] COL_CMD_MASK  = 8'h7F;
   localparam logic [7:0] COL_CMD_BASE  = 8'h40;
   localparam logic [7:0] CMD_START_LINE = 8'hC0;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h3F;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_REDRAW,
      MODE_CLEAR,
      MODE_INIT
   } mode_type;

   typedef enum logic [1:0] {
      PH_PAGE,
      PH_COLUMN,
      PH_DATA,
      PH_END
   } phase_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [6:0] pixel_x;
      logic [5:0] pixel_y;
      logic       pixel_value;
      logic [6:0] region_x;
      logic [5:0] region_y;
      logic [6:0] region_height;
      logic [7:0] region_width;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [1:0] chip_select;
      logic       is_data;
      logic [7:0] bus_byte;
   } rsp_type;

   function automatic logic [7:0] init_command(input logic [1:0] step);
      logic [7:0] cmd;
      unique case (step)
         2'd0:    cmd = PAGE_CMD_BASE;
         2'd1:    cmd = COL_CMD_BASE;
         2'd2:    cmd = CMD_START_LINE;
         default: cmd = CMD_DISPLAY_ON;
      endcase
      return cmd;
   endfunction

   function automatic logic [7:0] page_command(input logic [2:0] page);
      return ({5'd0, page} & PAGE_CMD_MASK) | PAGE_CMD_BASE;
   endfunction

   function automatic logic [7:0] column_command(input logic [6:0] column);
      return ({1'b0, column} & COL_CMD_MASK) | COL_CMD_BASE;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/glcd_framebuffer_refresh_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Graphic LCD frame store and refresh sequencer
// Holds a 128x64 page-organised image and turns redraw, clear and init
// requests into a stream of bus writes for a two-chip graphic LCD.
//
// Requests arrive on the req_ channel; every transaction is one opcode.
// Pixel transactions update the store at once. Redraw, clear and init start
// a sequence; each tick transaction afterwards yields one rsp_ transaction
// (a bus write, or the completion at the end). Other requests during a
// sequence are answered with a reject. Idle ticks give no response.
// Each request is handled on acceptance and its response is loaded into the
// output register, so one transaction per cycle is sustained while the
// receiver takes responses; the frame store has one read port, registered
// and addressed by the next column, so its row is ready for the data write.
// The store is kept as 128 rows of 64 bits, one row per column, with a valid
// flag per row, so clear and init empty it by clearing the flags.
// Reset returns the sequencer to idle and empties the store. When the
// receiver stalls, the output register holds its transaction and req_ready
// falls until it is taken.
// ----------------------------------------------------------------------------
module glcd_framebuffer_refresh_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire glcd_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output glcd_pkg::rsp_type     rsp_payload
);
   import glcd_pkg::*;

   mode_type   mode_ff, mode_in;
   phase_type  phase_ff, phase_in;
   logic [2:0] page_ff, page_in;
   logic [6:0] col_ff, col_in;
   logic [1:0] step_ff, step_in;
   logic [6:0] left_ff, left_in;
   logic [5:0] top_ff, top_in;
   logic [6:0] height_ff, height_in;
   logic [7:0] width_ff, width_in;

   logic [SCREEN_COLUMNS-1:0] row_valid_ff;
   logic [ROW_BITS-1:0]       store_mem [SCREEN_COLUMNS];
   logic [ROW_BITS-1:0]       rd_row_ff;
   logic                      rd_valid_ff;
   logic [ROW_BITS-1:0]       wr_mask;
   logic [ROW_BITS-1:0]       wr_bits;
   logic                      wr_en;
   logic                      store_clear;

   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_load;

   logic       accept, busy, is_tick, pix_in_range;
   logic [2:0] top_page;
   logic [7:0] page_end;
   logic       page_hit;
   logic [6:0] scan_start;
   logic [8:0] col_end;
   logic       col_found;
   logic       last_page;
   logic       last_screen_col;
   logic       last_chip_col;
   logic [6:0] local_col;
   logic [7:0] data_byte;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign busy        = (mode_ff != MODE_IDLE);
   assign is_tick     = (req_payload.opcode == OP_TICK);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign top_page   = top_ff[5:3];
   assign page_end   = {5'd0, top_page} + {1'b0, height_ff};
   assign page_hit   = (page_ff >= top_page) && ({5'd0, page_ff} < page_end);
   assign scan_start = (col_ff > left_ff) ? col_ff : left_ff;
   assign col_end    = {2'd0, left_ff} + {1'b0, width_ff};
   assign col_found  = page_hit && ({2'd0, scan_start} < col_end)
                       && ({1'b0, scan_start} < 8'(SCREEN_COLUMNS));
   assign last_page  = ({1'b0, page_ff} + 4'd1) >= 4'(PAGE_COUNT);
   assign last_screen_col = ({1'b0, col_ff} + 8'd1) >= 8'(SCREEN_COLUMNS);
   assign last_chip_col   = ({1'b0, col_ff} + 8'd1) >= 8'(CHIP_COLUMNS);
   assign local_col  = (scan_start < 7'(CHIP_COLUMNS)) ? scan_start
                       : scan_start - 7'(CHIP_COLUMNS);
   assign data_byte  = rd_valid_ff ? rd_row_ff[{page_ff, 3'b000} +: 8] : 8'd0;

   assign pix_in_range = ({1'b0, req_payload.pixel_x} < 8'(SCREEN_COLUMNS))
                         && ({1'b0, req_payload.pixel_y} < 7'(8 * PAGE_COUNT));
   assign wr_en       = accept && !busy && (req_payload.opcode == OP_PIXEL)
                        && pix_in_range;
   assign store_clear = accept && !busy && ((req_payload.opcode == OP_CLEAR)
                        || (req_payload.opcode == OP_INIT));
   assign wr_bits = ROW_BITS'({ {(ROW_BITS-1){1'b0}}, req_payload.pixel_value })
                    << req_payload.pixel_y;
   assign wr_mask = row_valid_ff[req_payload.pixel_x]
                    ? (ROW_BITS'(1) << req_payload.pixel_y) : {ROW_BITS{1'b1}};

   always_comb begin
      mode_in   = mode_ff;
      phase_in  = phase_ff;
      page_in   = page_ff;
      col_in    = col_ff;
      step_in   = step_ff;
      left_in   = left_ff;
      top_in    = top_ff;
      height_in = height_ff;
      width_in  = width_ff;
      if (accept) begin
         if (busy) begin
            if (is_tick) begin
               unique case (mode_ff)
                  MODE_REDRAW: begin
                     unique case (phase_ff)
                        PH_PAGE: begin
                           col_in   = '0;
                           phase_in = PH_COLUMN;
                        end
                        PH_DATA: begin
                           if (last_screen_col) begin
                              phase_in = PH_END;
                           end else begin
                              col_in   = col_ff + 7'd1;
                              phase_in = PH_COLUMN;
                           end
                        end
                        default: begin
                           if ((phase_ff == PH_COLUMN) && col_found) begin
                              col_in   = scan_start;
                              phase_in = PH_DATA;
                           end else if (last_page) begin
                              mode_in  = MODE_IDLE;
                              phase_in = PH_PAGE;
                              page_in  = '0;
                              col_in   = '0;
                              step_in  = '0;
                           end else begin
                              page_in  = page_ff + 3'd1;
                              col_in   = '0;
                              phase_in = PH_COLUMN;
                           end
                        end
                     endcase
                  end
                  MODE_CLEAR: begin
                     unique case (phase_ff)
                        PH_PAGE: begin
                           col_in   = '0;
                           phase_in = PH_COLUMN;
                        end
                        PH_COLUMN: begin
                           if (last_chip_col) begin
                              if (last_page) begin
                                 phase_in = PH_END;
                              end else begin
                                 page_in  = page_ff + 3'd1;
                                 phase_in = PH_PAGE;
                              end
                           end else begin
                              col_in = col_ff + 7'd1;
                           end
                        end
                        default: begin
                           mode_in  = MODE_IDLE;
                           phase_in = PH_PAGE;
                           page_in  = '0;
                           col_in   = '0;
                           step_in  = '0;
                        end
                     endcase
                  end
                  default: begin
                     if (step_ff == 2'd3) begin
                        step_in  = '0;
                        mode_in  = MODE_CLEAR;
                        phase_in = PH_PAGE;
                        page_in  = '0;
                        col_in   = '0;
                     end else begin
                        step_in = step_ff + 2'd1;
                     end
                  end
               endcase
            end
         end else begin
            unique case (req_payload.opcode)
               OP_REDRAW: begin
                  left_in   = req_payload.region_x;
                  top_in    = req_payload.region_y;
                  height_in = req_payload.region_height;
                  width_in  = req_payload.region_width;
                  mode_in   = MODE_REDRAW;
                  phase_in  = PH_PAGE;
                  page_in   = '0;
                  col_in    = '0;
                  step_in   = '0;
               end
               OP_CLEAR, OP_INIT: begin
                  mode_in  = (req_payload.opcode == OP_CLEAR) ? MODE_CLEAR : MODE_INIT;
                  phase_in = PH_PAGE;
                  page_in  = '0;
                  col_in   = '0;
                  step_in  = '0;
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_load = 1'b0;
      rsp_in   = '{result_kind: KIND_WRITE, chip_select: CHIP_BOTH, is_data: 1'b0,
                   bus_byte: 8'd0};
      if (accept && busy) begin
         rsp_load = 1'b1;
         if (!is_tick) begin
            rsp_in = '{result_kind: KIND_REJECT, chip_select: CHIP_A, is_data: 1'b0,
                       bus_byte: 8'd0};
         end else begin
            unique case (mode_ff)
               MODE_REDRAW: begin
                  unique case (phase_ff)
                     PH_PAGE: begin
                        rsp_in.bus_byte = page_command(page_ff);
                     end
                     PH_DATA: begin
                        rsp_in.chip_select = (col_ff < 7'(CHIP_COLUMNS)) ? CHIP_A : CHIP_B;
                        rsp_in.is_data     = 1'b1;
                        rsp_in.bus_byte    = data_byte;
                     end
                     default: begin
                        if ((phase_ff == PH_COLUMN) && col_found) begin
                           rsp_in.bus_byte = column_command(local_col);
                        end else if (last_page) begin
                           rsp_in = '{result_kind: KIND_DONE, chip_select: CHIP_A,
                                      is_data: 1'b0, bus_byte: 8'd0};
                        end else begin
                           rsp_in.bus_byte = page_command(page_ff + 3'd1);
                        end
                     end
                  endcase
               end
               MODE_CLEAR: begin
                  unique case (phase_ff)
                     PH_PAGE: begin
                        rsp_in.bus_byte = page_command(page_ff);
                     end
                     PH_COLUMN: begin
                        rsp_in.is_data = 1'b1;
                     end
                     default: begin
                        rsp_in = '{result_kind: KIND_DONE, chip_select: CHIP_A,
                                   is_data: 1'b0, bus_byte: 8'd0};
                     end
                  endcase
               end
               default: begin
                  rsp_in.bus_byte = init_command(step_ff);
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < ROW_BITS; i++) begin
            if (wr_mask[i]) begin
               store_mem[req_payload.pixel_x][i] <= wr_bits[i];
            end
         end
      end
      rd_row_ff   <= store_mem[col_in];
      rd_valid_ff <= row_valid_ff[col_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (store_clear) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[req_payload.pixel_x] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         phase_ff     <= PH_PAGE;
         page_ff      <= '0;
         col_ff       <= '0;
         step_ff      <= '0;
         left_ff      <= '0;
         top_ff       <= '0;
         height_ff    <= '0;
         width_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         phase_ff  <= phase_in;
         page_ff   <= page_in;
         col_ff    <= col_in;
         step_ff   <= step_in;
         left_ff   <= left_in;
         top_ff    <= top_in;
         height_ff <= height_in;
         width_ff  <= width_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graphic LCD refresh unit testbench
// Drives pixel, redraw, clear and init requests with tick streams through
// the request channel and checks every response against a cycle-free shadow
// of the frame store and refresh sequencer. Both channels idle and stall at
// random, and some requests wait until all outstanding responses have come.
// ----------------------------------------------------------------------------
module tb_top;
   import glcd_pkg::*;

   typedef struct {
      req_type req;
      bit      drain;
   } backlog_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   backlog_entry_type request_backlog[$];
   rsp_type           awaited_results[$];
   int                mismatch_count = 0;
   int                gap_left = 0;
   int                stall_left = 0;

   // Shadow of the block's state.
   logic [7:0] shadow_store [0:SCREEN_COLUMNS-1][0:PAGE_COUNT-1];
   mode_type   shadow_mode = MODE_IDLE;
   phase_type  shadow_phase = PH_PAGE;
   logic [2:0] shadow_page = '0;
   logic [6:0] shadow_column = '0;
   logic [1:0] shadow_step = '0;
   logic [6:0] region_left = '0;
   logic [5:0] region_top = '0;
   logic [6:0] region_rows = '0;
   logic [7:0] region_cols = '0;

   glcd_framebuffer_refresh_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit region_hit(int x, int p, int left, int top, int rows, int cols);
      int top_page;
      top_page = top / 8;
      return x >= left && x < left + cols && p >= top_page && p < top_page + rows;
   endfunction

   function automatic void wipe_store();
      for (int x = 0; x < SCREEN_COLUMNS; x++) begin
         for (int p = 0; p < PAGE_COUNT; p++) begin
            shadow_store[x][p] = 8'h00;
         end
      end
   endfunction

   function automatic void return_to_idle();
      shadow_mode   = MODE_IDLE;
      shadow_phase  = PH_PAGE;
      shadow_page   = '0;
      shadow_column = '0;
      shadow_step   = '0;
   endfunction

   function automatic rsp_type page_write();
      shadow_column = '0;
      shadow_phase  = PH_COLUMN;
      return rsp_type'{KIND_WRITE, CHIP_BOTH, 1'b0,
                       ({5'd0, shadow_page} & PAGE_CMD_MASK) | PAGE_CMD_BASE};
   endfunction

   function automatic rsp_type redraw_tick();
      int x;
      int chip_column;
      if (shadow_phase == PH_PAGE) begin
         return page_write();
      end
      if (shadow_phase == PH_DATA) begin
         x = shadow_column;
         if (x + 1 >= SCREEN_COLUMNS) begin
            shadow_phase = PH_END;
         end else begin
            shadow_column = 7'(x + 1);
            shadow_phase  = PH_COLUMN;
         end
         return rsp_type'{KIND_WRITE, (x < CHIP_COLUMNS) ? CHIP_A : CHIP_B, 1'b1,
                          shadow_store[x][shadow_page]};
      end
      if (shadow_phase == PH_COLUMN) begin
         for (int c = shadow_column; c < SCREEN_COLUMNS; c++) begin
            if (region_hit(c, shadow_page, region_left, region_top, region_rows,
                           region_cols)) begin
               chip_column   = (c < CHIP_COLUMNS) ? c : c - CHIP_COLUMNS;
               shadow_column = 7'(c);
               shadow_phase  = PH_DATA;
               return rsp_type'{KIND_WRITE, CHIP_BOTH, 1'b0,
                                (8'(chip_column) & COL_CMD_MASK) | COL_CMD_BASE};
            end
         end
      end
      if (shadow_page + 1 >= PAGE_COUNT) begin
         return_to_idle();
         return rsp_type'{KIND_DONE, 2'd0, 1'b0, 8'h00};
      end
      shadow_page = shadow_page + 3'd1;
      return page_write();
   endfunction

   function automatic rsp_type clear_tick();
      if (shadow_phase == PH_PAGE) begin
         return page_write();
      end
      if (shadow_phase == PH_COLUMN) begin
         if (shadow_column + 1 >= CHIP_COLUMNS) begin
            if (shadow_page + 1 >= PAGE_COUNT) begin
               shadow_phase = PH_DATA;
            end else begin
               shadow_page  = shadow_page + 3'd1;
               shadow_phase = PH_PAGE;
            end
         end else begin
            shadow_column = shadow_column + 7'd1;
         end
         return rsp_type'{KIND_WRITE, CHIP_BOTH, 1'b1, 8'h00};
      end
      return_to_idle();
      return rsp_type'{KIND_DONE, 2'd0, 1'b0, 8'h00};
   endfunction

   function automatic rsp_type init_tick();
      logic [7:0] command;
      case (shadow_step)
         2'd0:    command = PAGE_CMD_BASE;
         2'd1:    command = COL_CMD_BASE;
         2'd2:    command = CMD_START_LINE;
         default: command = CMD_DISPLAY_ON;
      endcase
      if (shadow_step == 2'd3) begin
         return_to_idle();
         shadow_mode = MODE_CLEAR;
      end else begin
         shadow_step = shadow_step + 2'd1;
      end
      return rsp_type'{KIND_WRITE, CHIP_BOTH, 1'b0, command};
   endfunction

   // Applies one accepted request to the shadow; returns 1 when a response follows.
   function automatic bit lcd_next_result(input req_type r, output rsp_type result);
      result = '0;
      if (shadow_mode != MODE_IDLE) begin
         if (r.opcode != OP_TICK) begin
            result = rsp_type'{KIND_REJECT, 2'd0, 1'b0, 8'h00};
         end else if (shadow_mode == MODE_REDRAW) begin
            result = redraw_tick();
         end else if (shadow_mode == MODE_CLEAR) begin
            result = clear_tick();
         end else begin
            result = init_tick();
         end
         return 1'b1;
      end
      case (r.opcode)
         OP_PIXEL: begin
            if (r.pixel_x < SCREEN_COLUMNS && r.pixel_y < 8 * PAGE_COUNT) begin
               shadow_store[r.pixel_x][r.pixel_y[5:3]][r.pixel_y[2:0]] = r.pixel_value;
            end
         end
         OP_REDRAW: begin
            region_left = r.region_x;
            region_top  = r.region_y;
            region_rows = r.region_height;
            region_cols = r.region_width;
            return_to_idle();
            shadow_mode = MODE_REDRAW;
         end
         OP_CLEAR, OP_INIT: begin
            wipe_store();
            return_to_idle();
            shadow_mode = (r.opcode == OP_CLEAR) ? MODE_CLEAR : MODE_INIT;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic bit quiet_stretch();
      return (($time / 2000) % 5) == 0;
   endfunction

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_stretch() || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Driver.
   always @(posedge clock) begin
      rsp_type result;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (lcd_next_result(req_payload, result)) begin
               awaited_results.push_back(result);
            end
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_backlog.size() > 0 &&
                         !(request_backlog[0].drain && awaited_results.size() > 0)) begin
               req_valid   <= 1'b1;
               req_payload <= request_backlog[0].req;
               void'(request_backlog.pop_front());
               gap_left = draw_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, expected, actual);
         mismatch_count++;
      end
   endtask

   // Monitor.
   always @(posedge clock) begin
      rsp_type wanted;
      int r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t ns: unexpected transaction, expected none, actual 0x%0h",
                        $time, rsp_payload);
               mismatch_count++;
            end else begin
               wanted = awaited_results.pop_front();
               check_field("result_kind", wanted.result_kind, rsp_payload.result_kind);
               check_field("chip_select", wanted.chip_select, rsp_payload.chip_select);
               check_field("is_data", wanted.is_data, rsp_payload.is_data);
               check_field("bus_byte", wanted.bus_byte, rsp_payload.bus_byte);
            end
         end
         if (quiet_stretch()) begin
            stall_left = 0;
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_ready <= 1'b1;
            end else begin
               stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
               rsp_ready <= 1'b0;
            end
         end
      end
   end

   // Stimulus.
   function automatic req_type random_req(logic [2:0] op);
      req_type r;
      r.opcode        = op;
      r.pixel_x       = 7'($urandom_range(0, 127));
      r.pixel_y       = 6'($urandom_range(0, 63));
      r.pixel_value   = 1'($urandom_range(0, 1));
      r.region_x      = 7'($urandom_range(0, 127));
      r.region_y      = 6'($urandom_range(0, 63));
      r.region_height = 7'($urandom_range(0, 127));
      r.region_width  = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic req_type pixel_req(int x, int y, bit value);
      req_type r;
      r             = random_req(OP_PIXEL);
      r.pixel_x     = 7'(x);
      r.pixel_y     = 6'(y);
      r.pixel_value = value;
      return r;
   endfunction

   function automatic req_type region_req(int left, int top, int rows, int cols);
      req_type r;
      r               = random_req(OP_REDRAW);
      r.region_x      = 7'(left);
      r.region_y      = 6'(top);
      r.region_height = 7'(rows);
      r.region_width  = 8'(cols);
      return r;
   endfunction

   function automatic int redraw_ticks(req_type r);
      int hits;
      hits = 0;
      for (int p = 0; p < PAGE_COUNT; p++) begin
         for (int x = 0; x < SCREEN_COLUMNS; x++) begin
            if (region_hit(x, p, r.region_x, r.region_y, r.region_height, r.region_width))
               hits++;
         end
      end
      return PAGE_COUNT + 1 + 2 * hits;
   endfunction

   task automatic queue_req(req_type r, bit drain);
      backlog_entry_type e;
      e.req   = r;
      e.drain = drain;
      request_backlog.push_back(e);
   endtask

   // Ticks that carry a sequence to its end, with rejected requests mixed in.
   task automatic queue_ticks(int count, int noise_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            queue_req(random_req(3'($urandom_range(1, 7))), 1'b0);
         queue_req(random_req(OP_TICK), 1'b0);
      end
   endtask

   task automatic queue_redraw(req_type r, bit drain, int noise_pct);
      queue_req(r, drain);
      queue_ticks(redraw_ticks(r), noise_pct);
   endtask

   initial begin
      int choice;
      int rows;
      int cols;
      int random_count;
      int clear_len;
      clear_len = PAGE_COUNT * (CHIP_COLUMNS + 1) + 1;

      queue_req(random_req(OP_TICK), 1'b0);
      queue_req(random_req(3'd5), 1'b0);
      queue_req(random_req(3'd7), 1'b0);
      queue_req(random_req(OP_INIT), 1'b0);
      queue_ticks(4 + clear_len, 2);
      queue_req(pixel_req(0, 0, 1'b1), 1'b1);
      queue_req(pixel_req(127, 63, 1'b1), 1'b0);
      queue_req(pixel_req(63, 7, 1'b1), 1'b0);
      queue_req(pixel_req(64, 8, 1'b1), 1'b0);
      queue_req(pixel_req(5, 5, 1'b1), 1'b0);
      queue_req(pixel_req(5, 5, 1'b0), 1'b0);
      queue_redraw(region_req(0, 0, 2, 68), 1'b0, 1);
      queue_redraw(region_req(30, 9, 1, 0), 1'b0, 0);
      queue_redraw(region_req(127, 63, 64, 128), 1'b0, 10);
      queue_redraw(region_req(40, 20, 2, 50), 1'b0, 5);
      queue_req(random_req(OP_CLEAR), 1'b0);
      queue_ticks(clear_len, 2);
      queue_redraw(region_req(60, 0, 8, 8), 1'b0, 0);

      random_count = 2000;
      while (request_backlog.size() < random_count) begin
         choice = $urandom_range(0, 99);
         if (choice < 45) begin
            queue_req(random_req(OP_PIXEL), 1'b0);
         end else if (choice < 52) begin
            queue_req(random_req(OP_TICK), 1'b0);
         end else if (choice < 56) begin
            queue_req(random_req(3'($urandom_range(5, 7))), 1'b0);
         end else if (choice < 98) begin
            rows = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 3);
            cols = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 128) : $urandom_range(0, 12);
            queue_redraw(region_req($urandom_range(0, 127), $urandom_range(0, 63), rows, cols),
                         $urandom_range(0, 19) == 0, 5);
         end else begin
            queue_req(random_req((choice == 98) ? OP_CLEAR : OP_INIT), $urandom_range(0, 3) == 0);
            queue_ticks((choice == 98) ? clear_len : clear_len + 4, 3);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() > 0 || req_valid || awaited_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("glcd_framebuffer_refresh_unit verification clean");
      end else begin
         $display("glcd_framebuffer_refresh_unit verification failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("glcd_framebuffer_refresh_unit verification failed");
      $finish;
   end

endmodule
